// ----- design/pisep_pkg.sv -----
// Shared types and constants for the positional PID block with integral separation.
// Used by every module of the block except the queue; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pisep_pkg;

   localparam int GAIN_FRAC_BITS_DEFAULT = 8;
   localparam int INTEGRAL_WIDTH_DEFAULT = 24;
   localparam int QUEUE_DEPTH            = 4;

   // Error is target minus sample, the difference is error minus previous error.
   localparam int ERR_W  = 13;
   localparam int DIFF_W = 14;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [11:0]        TARGET_RESET = 12'd3200;
   localparam logic [11:0]        BAND_RESET   = 12'd500;
   localparam logic signed [31:0] VENT_RESET   = 32'sd3400;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TARGET_PRESSURE = 3'd0,
      CSR_SEPARATION_BAND = 3'd1,
      CSR_GAIN_P          = 3'd2,
      CSR_GAIN_I          = 3'd3,
      CSR_GAIN_D          = 3'd4,
      CSR_VENT_THRESHOLD  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [11:0]        target_pressure;
      logic [11:0]        separation_band;
      logic [15:0]        gain_p;
      logic [15:0]        gain_i;
      logic [15:0]        gain_d;
      logic signed [31:0] vent_threshold;
   } cfg_type;

endpackage

`default_nettype wire

// ----- design/pisep_csr.sv -----
// Configuration register file of the PID block.
// Depends on pisep_pkg for the register index codes and the cfg_type bundle.
`timescale 1ns / 1ps
`default_nettype none

module pisep_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [pisep_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pisep_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output pisep_pkg::cfg_type                    cfg
);
   import pisep_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_TARGET_PRESSURE: cfg_in.target_pressure = csr_wdata[11:0];
            CSR_SEPARATION_BAND: cfg_in.separation_band = csr_wdata[11:0];
            CSR_GAIN_P:          cfg_in.gain_p          = csr_wdata[15:0];
            CSR_GAIN_I:          cfg_in.gain_i          = csr_wdata[15:0];
            CSR_GAIN_D:          cfg_in.gain_d          = csr_wdata[15:0];
            CSR_VENT_THRESHOLD:  cfg_in.vent_threshold  = signed'(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_pressure <= TARGET_RESET;
         cfg_ff.separation_band <= BAND_RESET;
         cfg_ff.gain_p          <= '0;
         cfg_ff.gain_i          <= '0;
         cfg_ff.gain_d          <= '0;
         cfg_ff.vent_threshold  <= VENT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/pisep_front.sv -----
// Front end of the PID block: forms the error, keeps the saturating integral and
// the previous error, and classifies each sample against the separation band.
// Depends on pisep_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pisep_front #(
   parameter int INTEGRAL_WIDTH = pisep_pkg::INTEGRAL_WIDTH_DEFAULT,
   parameter int ENTRY_W        = pisep_pkg::ERR_W + pisep_pkg::DIFF_W + INTEGRAL_WIDTH + 1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pisep_pkg::cfg_type cfg,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [11:0]        req_pressure_sample,
   input  wire logic               queue_full,
   output logic                    queue_push,
   output logic [ENTRY_W-1:0]      queue_entry
);
   import pisep_pkg::*;

   localparam int SUM_W = INTEGRAL_WIDTH + 1;
   localparam logic signed [INTEGRAL_WIDTH-1:0] INT_MAX = {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
   localparam logic signed [INTEGRAL_WIDTH-1:0] INT_MIN = {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};

   logic signed [ERR_W-1:0]          prev_error_ff;
   logic signed [ERR_W-1:0]          prev_error_in;
   logic signed [INTEGRAL_WIDTH-1:0] integral_ff;
   logic signed [INTEGRAL_WIDTH-1:0] integral_in;

   logic                             accept;
   logic signed [ERR_W-1:0]          err;
   logic [11:0]                      mag;
   logic signed [DIFF_W-1:0]         diff;
   logic signed [SUM_W-1:0]          sum;
   logic signed [INTEGRAL_WIDTH-1:0] sum_sat;
   logic                             in_band;

   assign req_stall  = queue_full;
   assign accept     = req_valid && !queue_full;
   assign queue_push = accept;

   assign err     = signed'({1'b0, cfg.target_pressure}) - signed'({1'b0, req_pressure_sample});
   assign mag     = err[ERR_W-1] ? 12'(-err) : err[11:0];
   assign in_band = (mag <= cfg.separation_band);
   assign diff    = DIFF_W'(err) - DIFF_W'(prev_error_ff);
   assign sum     = SUM_W'(integral_ff) + SUM_W'(err);

   // The top two bits of the widened sum disagree only on overflow.
   always_comb begin
      if (sum[SUM_W-1] != sum[SUM_W-2]) begin
         sum_sat = sum[SUM_W-1] ? INT_MIN : INT_MAX;
      end else begin
         sum_sat = sum[INTEGRAL_WIDTH-1:0];
      end
   end

   assign queue_entry = {in_band, err, diff, sum_sat};

   always_comb begin
      prev_error_in = prev_error_ff;
      integral_in   = integral_ff;
      if (accept) begin
         prev_error_in = err;
         integral_in   = sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_error_ff <= '0;
         integral_ff   <= '0;
      end else begin
         prev_error_ff <= prev_error_in;
         integral_ff   <= integral_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/pisep_queue.sv -----
// Small first-in first-out queue between the front and back of the PID block.
// Generic in depth and entry width; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module pisep_queue #(
   parameter int DEPTH      = 4,
   parameter int DATA_WIDTH = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire logic [DATA_WIDTH-1:0] push_data,
   output logic                       full,
   input  wire logic                  pop,
   output logic                       not_empty,
   output logic [DATA_WIDTH-1:0]      pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff;
   logic [PTR_W-1:0]      wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff;
   logic [PTR_W-1:0]      rd_ptr_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/pisep_back.sv -----
// Back end of the PID block: three gain multiplies, the sum, the vent compare,
// the fraction drop and the drive saturation, in three registered stages.
// Depends on pisep_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pisep_back #(
   parameter int GAIN_FRAC_BITS = pisep_pkg::GAIN_FRAC_BITS_DEFAULT,
   parameter int INTEGRAL_WIDTH = pisep_pkg::INTEGRAL_WIDTH_DEFAULT,
   parameter int ENTRY_W        = pisep_pkg::ERR_W + pisep_pkg::DIFF_W + INTEGRAL_WIDTH + 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pisep_pkg::cfg_type   cfg,
   input  wire logic                 queue_not_empty,
   input  wire logic [ENTRY_W-1:0]   queue_entry,
   output logic                      queue_pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic signed [31:0]        rsp_drive_value,
   output logic signed [23:0]        rsp_error_integral,
   output logic                      rsp_vent_open
);
   import pisep_pkg::*;

   localparam int P_W    = 17 + ERR_W;
   localparam int D_W    = 17 + DIFF_W;
   localparam int I_W    = 17 + INTEGRAL_WIDTH;
   localparam int ACC_W  = INTEGRAL_WIDTH + 19;
   localparam int WIDE_W = (ACC_W > 33 + GAIN_FRAC_BITS) ? ACC_W : 33 + GAIN_FRAC_BITS;
   localparam int IX_W   = (INTEGRAL_WIDTH > 24) ? INTEGRAL_WIDTH : 24;
   localparam logic signed [WIDE_W-1:0] DRV_MAX = WIDE_W'(32'sh7fffffff);
   localparam logic signed [WIDE_W-1:0] DRV_MIN = WIDE_W'(32'sh80000000);

   // Queue entry fields.
   logic                             q_in_band;
   logic signed [ERR_W-1:0]          q_err;
   logic signed [DIFF_W-1:0]         q_diff;
   logic signed [INTEGRAL_WIDTH-1:0] q_int;

   assign {q_in_band, q_err, q_diff, q_int} = queue_entry;

   logic adv_out;
   logic adv_s2;
   logic adv_s1;

   // Stage 1: products.
   logic                             s1_valid_ff;
   logic                             s1_valid_in;
   logic signed [P_W-1:0]            s1_p_ff;
   logic signed [D_W-1:0]            s1_d_ff;
   logic signed [I_W-1:0]            s1_i_ff;
   logic signed [INTEGRAL_WIDTH-1:0] s1_int_ff;

   // Stage 2: accumulator.
   logic                             s2_valid_ff;
   logic                             s2_valid_in;
   logic signed [ACC_W-1:0]          s2_acc_ff;
   logic signed [ACC_W-1:0]          s2_acc_in;
   logic signed [INTEGRAL_WIDTH-1:0] s2_int_ff;

   // Output register.
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic signed [31:0]               drive_ff;
   logic signed [31:0]               drive_in;
   logic signed [23:0]               integral_ff;
   logic signed [23:0]               integral_in;
   logic                             vent_ff;
   logic                             vent_in;

   logic signed [16:0]               gain_p_s;
   logic signed [16:0]               gain_i_s;
   logic signed [16:0]               gain_d_s;
   logic signed [WIDE_W-1:0]         acc_wide;
   logic signed [WIDE_W-1:0]         thr_wide;
   logic signed [WIDE_W-1:0]         acc_floor;
   logic signed [IX_W-1:0]           int_ext;

   assign adv_out   = !rsp_valid_ff || !rsp_stall;
   assign adv_s2    = !s2_valid_ff || adv_out;
   assign adv_s1    = !s1_valid_ff || adv_s2;
   assign queue_pop = queue_not_empty && adv_s1;

   assign s1_valid_in  = adv_s1 ? queue_not_empty : s1_valid_ff;
   assign s2_valid_in  = adv_s2 ? s1_valid_ff : s2_valid_ff;
   assign rsp_valid_in = adv_out ? s2_valid_ff : rsp_valid_ff;

   assign gain_p_s = signed'({1'b0, cfg.gain_p});
   assign gain_i_s = signed'({1'b0, cfg.gain_i});
   assign gain_d_s = signed'({1'b0, cfg.gain_d});

   assign s2_acc_in = ACC_W'(s1_p_ff) + ACC_W'(s1_d_ff) + ACC_W'(s1_i_ff);

   // The vent compare works on the full-precision sum; the arithmetic shift floors.
   assign acc_wide  = WIDE_W'(s2_acc_ff);
   assign thr_wide  = WIDE_W'(cfg.vent_threshold) <<< GAIN_FRAC_BITS;
   assign acc_floor = acc_wide >>> GAIN_FRAC_BITS;
   assign vent_in   = (acc_wide > thr_wide);
   assign int_ext   = IX_W'(s2_int_ff);
   assign integral_in = int_ext[23:0];

   always_comb begin
      if (acc_floor > DRV_MAX) begin
         drive_in = 32'sh7fffffff;
      end else if (acc_floor < DRV_MIN) begin
         drive_in = 32'sh80000000;
      end else begin
         drive_in = acc_floor[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         s1_p_ff   <= P_W'(gain_p_s) * P_W'(q_err);
         s1_d_ff   <= D_W'(gain_d_s) * D_W'(q_diff);
         s1_i_ff   <= q_in_band ? I_W'(gain_i_s) * I_W'(q_int) : '0;
         s1_int_ff <= q_int;
      end
      if (adv_s2 && s1_valid_ff) begin
         s2_acc_ff <= s2_acc_in;
         s2_int_ff <= s1_int_ff;
      end
      if (adv_out && s2_valid_ff) begin
         drive_ff    <= drive_in;
         integral_ff <= integral_in;
         vent_ff     <= vent_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_drive_value    = drive_ff;
   assign rsp_error_integral = integral_ff;
   assign rsp_vent_open      = vent_ff;

endmodule

`default_nettype wire

// ----- design/positional_pid_integral_separation.sv -----
// Positional PID controller with integral separation for a pressure loop.
//
// Channels: req_ carries one 12-bit pressure sample per transfer; rsp_ returns
// one result per sample (saturated drive, 24-bit integral, vent flag) in order.
// A transfer happens on a rising edge where valid is high and stall is low.
// csr_ writes one of six registers (target, band, three Q8.8 gains, vent
// threshold) on an edge where csr_valid and csr_ready are high; csr_ready is
// always high, and registers are meant to change only while the block is idle.
//
// Path: a sample is taken into the queue by the front end, then passes the multiply,
// sum and saturate stages in the back before its result is presented.
// Throughput: one sample per cycle while req_stall is low, set by the front end's
// update of the integral and previous error as each sample is taken.
// Stalls: while rsp_stall is high the back pipeline and then the four-entry
// queue fill; req_stall rises only when the queue is full.
// Reset clears the integral, the previous error and all pipeline valid bits
// and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module positional_pid_integral_separation #(
   parameter int GAIN_FRAC_BITS = pisep_pkg::GAIN_FRAC_BITS_DEFAULT,
   parameter int INTEGRAL_WIDTH = pisep_pkg::INTEGRAL_WIDTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [11:0]                       req_pressure_sample,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [31:0]                     rsp_drive_value,
   output logic signed [23:0]                     rsp_error_integral,
   output logic                                   rsp_vent_open,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [pisep_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pisep_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pisep_pkg::*;

   localparam int ENTRY_W = ERR_W + DIFF_W + INTEGRAL_WIDTH + 1;

   cfg_type              cfg;
   logic                 queue_full;
   logic                 queue_push;
   logic [ENTRY_W-1:0]   push_entry;
   logic                 queue_pop;
   logic                 queue_not_empty;
   logic [ENTRY_W-1:0]   pop_entry;

   pisep_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pisep_front #(
      .INTEGRAL_WIDTH (INTEGRAL_WIDTH),
      .ENTRY_W        (ENTRY_W)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_pressure_sample (req_pressure_sample),
      .queue_full          (queue_full),
      .queue_push          (queue_push),
      .queue_entry         (push_entry)
   );

   pisep_queue #(
      .DEPTH      (QUEUE_DEPTH),
      .DATA_WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (push_entry),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .pop_data  (pop_entry)
   );

   pisep_back #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
      .INTEGRAL_WIDTH (INTEGRAL_WIDTH),
      .ENTRY_W        (ENTRY_W)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .queue_not_empty    (queue_not_empty),
      .queue_entry        (pop_entry),
      .queue_pop          (queue_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_drive_value    (rsp_drive_value),
      .rsp_error_integral (rsp_error_integral),
      .rsp_vent_open      (rsp_vent_open)
   );

endmodule

`default_nettype wire
